### rtl/brb_pkg.sv
// shared types, codes and ring pointer helpers for the byte ring line extractor
package brb_pkg;

    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int LVL_W  = 6;

    // request codes
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_DETECT = 3'd2;
    localparam logic [2:0] REQ_TAKE   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] push_byte;
        logic [7:0] delim_char;
        logic [5:0] read_count;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       found;
        logic [5:0] line_length;
        logic [1:0] status;
        logic       dropped;
        logic [5:0] level;
        logic       last;
    } t_rsp;

    // (a + b) mod DEPTH, both below DEPTH
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // bytes held between tail and head
    function automatic logic [LVL_W-1:0] ring_level(input logic [AW-1:0] head,
                                                    input logic [AW-1:0] tail);
        logic [AW:0] d;
        if (head >= tail) begin
            d = {1'b0, head} - {1'b0, tail};
        end else begin
            d = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, tail};
        end
        return LVL_W'(d);
    endfunction

endpackage

### rtl/brb_store.sv
// byte storage of the ring: one write port, one registered read port
module brb_store (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [brb_pkg::AW-1:0] i_waddr,
    input  logic [7:0]             i_wdata,
    input  logic                   i_re,
    input  logic [brb_pkg::AW-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [brb_pkg::DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/byte_ring_buffer_line_extract_top.sv
// top level of the byte ring with delimiter search and line extraction
// Receive byte ring of 64 entries holding at most 63 bytes (one slot stays empty);
// a push on a full ring drops the oldest byte and flags it. Requests are taken one
// at a time: o_req_stall is low only while the sequencer is idle. Every request
// sends at least one word out; pop, take-line and read-count send one word per
// removed byte, the final one marked by last. Timing is set by the byte memory with
// its registered read, walked by one pointer adder and one byte comparator. A detect
// reads and then compares each held byte from the tail in turn (at most 63 bytes)
// until the delimiter or the end; a removal reads each byte from the tail and then
// sends it out; a take-line first searches and then removes the line. Output stall
// only stretches a request; a finished word waits in the output register while the
// next request is accepted.
module byte_ring_buffer_line_extract_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  brb_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output brb_pkg::t_rsp  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SR_RD,
        S_SR_CMP,
        S_DR_RD,
        S_DR_OUT,
        S_EMIT
    } t_state;

    t_state                         r_state, n_state;
    logic [brb_pkg::AW-1:0]         r_head, n_head;
    logic [brb_pkg::AW-1:0]         r_tail, n_tail;
    logic [brb_pkg::AW-1:0]         r_off, n_off;     // search offset from tail
    logic [brb_pkg::AW-1:0]         r_cnt, n_cnt;     // bytes left to remove
    logic [2:0]                     r_type, n_type;
    logic [7:0]                     r_delim, n_delim;
    logic                           r_fd, n_fd;
    logic [5:0]                     r_len, n_len;
    logic [brb_pkg::LVL_W-1:0]      r_lvl, n_lvl;     // level after the request
    brb_pkg::t_rsp                  r_pend, n_pend;   // single-word answer
    logic                           r_out_valid, n_out_valid;
    brb_pkg::t_rsp                  r_out, n_out;

    logic                           w_acc;
    logic                           w_out_free;
    logic                           w_load;
    logic [brb_pkg::LVL_W-1:0]      w_level;
    logic                           w_we, w_re;
    logic [brb_pkg::AW-1:0]         w_waddr, w_raddr;
    logic [7:0]                     w_rdata;
    logic [brb_pkg::AW-1:0]         w_head_inc;
    logic [brb_pkg::LVL_W:0]        w_take;
    logic [brb_pkg::LVL_W:0]        w_off_nx;

    brb_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req.push_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign w_acc       = i_req_valid && !o_req_stall;
    assign w_out_free  = !r_out_valid || !i_rsp_stall;
    assign w_level     = brb_pkg::ring_level(r_head, r_tail);
    assign w_head_inc  = brb_pkg::ptr_inc(r_head);
    assign w_off_nx    = {1'b0, brb_pkg::LVL_W'(r_off)} + (brb_pkg::LVL_W+1)'(1);

    // read-count takes the smaller of the request and the level
    assign w_take = ({1'b0, i_req.read_count} < {1'b0, w_level}) ?
                    {1'b0, i_req.read_count} : {1'b0, w_level};

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_type      = r_type;
        n_delim     = r_delim;
        n_fd        = r_fd;
        n_len       = r_len;
        n_lvl       = r_lvl;
        n_pend      = r_pend;
        n_out       = r_out;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_head;
        w_raddr     = r_tail;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_type        = i_req.req_type;
                    n_delim       = i_req.delim_char;
                    n_pend        = '0;
                    n_pend.last   = 1'b1;
                    n_pend.level  = w_level;
                    n_fd          = 1'b0;
                    n_len         = '0;
                    n_off         = '0;
                    n_state       = S_EMIT;
                    unique case (i_req.req_type) inside
                        brb_pkg::REQ_PUSH: begin
                            w_we   = 1'b1;
                            n_head = w_head_inc;
                            if (w_head_inc == r_tail) begin
                                // full: oldest byte goes
                                n_tail         = brb_pkg::ptr_inc(r_tail);
                                n_pend.dropped = 1'b1;
                            end else begin
                                n_pend.level = w_level + brb_pkg::LVL_W'(1);
                            end
                        end
                        brb_pkg::REQ_POP: begin
                            if (w_level == '0) begin
                                n_pend.status = brb_pkg::STAT_EMPTY;
                            end else begin
                                n_cnt   = brb_pkg::AW'(1);
                                n_lvl   = w_level - brb_pkg::LVL_W'(1);
                                n_state = S_DR_RD;
                            end
                        end
                        brb_pkg::REQ_DETECT, brb_pkg::REQ_TAKE: begin
                            if (w_level == '0) begin
                                n_pend.status = brb_pkg::STAT_EMPTY;
                            end else begin
                                n_state = S_SR_RD;
                            end
                        end
                        brb_pkg::REQ_READ: begin
                            if (w_take == '0) begin
                                n_pend.status = (w_level == '0) ?
                                                brb_pkg::STAT_EMPTY : brb_pkg::STAT_OK;
                            end else begin
                                n_cnt   = brb_pkg::AW'(w_take);
                                n_lvl   = w_level - brb_pkg::LVL_W'(w_take);
                                n_state = S_DR_RD;
                            end
                        end
                        default: begin
                            // unused codes answer with the level only
                        end
                    endcase
                end
            end
            S_SR_RD: begin
                w_re    = 1'b1;
                w_raddr = brb_pkg::ptr_add(r_tail, r_off);
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                if (w_rdata == r_delim) begin
                    if (r_type == brb_pkg::REQ_TAKE) begin
                        n_cnt   = brb_pkg::AW'(w_off_nx);
                        n_fd    = 1'b1;
                        n_len   = 6'(w_off_nx);
                        n_lvl   = w_level - brb_pkg::LVL_W'(w_off_nx);
                        n_state = S_DR_RD;
                    end else begin
                        n_pend.found = 1'b1;
                        n_state      = S_EMIT;
                    end
                end else if (w_off_nx == {1'b0, w_level}) begin
                    n_pend.status = brb_pkg::STAT_NOTFOUND;
                    n_state       = S_EMIT;
                end else begin
                    n_off   = brb_pkg::AW'(w_off_nx);
                    n_state = S_SR_RD;
                end
            end
            S_DR_RD: begin
                w_re    = 1'b1;
                w_raddr = r_tail;
                n_state = S_DR_OUT;
            end
            S_DR_OUT: begin
                if (w_out_free) begin
                    w_load            = 1'b1;
                    n_out             = '0;
                    n_out.out_byte    = w_rdata;
                    n_out.has_byte    = 1'b1;
                    n_out.found       = r_fd;
                    n_out.line_length = r_len;
                    n_out.status      = brb_pkg::STAT_OK;
                    n_out.level       = r_lvl;
                    n_out.last        = (r_cnt == brb_pkg::AW'(1));
                    n_tail            = brb_pkg::ptr_inc(r_tail);
                    n_cnt             = r_cnt - brb_pkg::AW'(1);
                    n_state           = (r_cnt == brb_pkg::AW'(1)) ? S_IDLE : S_DR_RD;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_out   = r_pend;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register: filled on load, emptied when taken
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
        r_off   <= n_off;
        r_cnt   <= n_cnt;
        r_type  <= n_type;
        r_delim <= n_delim;
        r_fd    <= n_fd;
        r_len   <= n_len;
        r_lvl   <= n_lvl;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // a push always leaves at least one byte held
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.req_type == brb_pkg::REQ_PUSH) |=> (w_level != '0))
        else $error("ring empty after push");

    // removal never starts with nothing left to remove
    a_drain_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR_RD) |-> (r_cnt != '0))
        else $error("drain with zero count");

    // the search never walks past the held bytes
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_CMP) |-> ({1'b0, brb_pkg::LVL_W'(r_off)} < {1'b0, w_level}))
        else $error("search offset beyond level");

    // the last word of a request returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out.last) |=> (r_state == S_IDLE))
        else $error("last word without return to idle");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the byte ring with delimiter search and line extraction
module tb_top;
    import brb_pkg::*;

    // request codes beyond read-count change nothing and are answered with the level only
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam logic [7:0] LINE_FEED    = 8'h0A;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         SETTLE_CYCLES = 300;

    // ring predictor plus the queue of words it expects back
    class ring_scoreboard;
        bit [7:0]    ring_mem [DEPTH];
        bit [AW-1:0] head_ptr;
        bit [AW-1:0] tail_ptr;
        t_rsp        expected_q [$];
        int          errors;

        function int held_count();
            return (int'(head_ptr) + DEPTH - int'(tail_ptr)) % DEPTH;
        endfunction

        function bit [AW-1:0] next_slot(bit [AW-1:0] p);
            return AW'((int'(p) + 1) % DEPTH);
        endfunction

        // offset of the first matching byte from the tail, -1 when absent
        function int delim_offset(bit [7:0] d);
            int n;
            n = held_count();
            for (int i = 0; i < n; i++) begin
                if (ring_mem[(int'(tail_ptr) + i) % DEPTH] == d) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // one word per removed byte, level is the one after the whole request
        function void remove_bytes(int cnt, bit fd, int len);
            t_rsp w;
            int   lv;
            lv = held_count() - cnt;
            for (int i = 0; i < cnt; i++) begin
                w             = '0;
                w.out_byte    = ring_mem[tail_ptr];
                w.has_byte    = 1'b1;
                w.found       = fd;
                w.line_length = LVL_W'(len);
                w.level       = LVL_W'(lv);
                w.last        = (i == cnt - 1);
                tail_ptr      = next_slot(tail_ptr);
                expected_q.push_back(w);
            end
        endfunction

        function void note_request(t_req r);
            t_rsp w;
            int   n;
            int   pos;
            int   take;
            n      = held_count();
            w      = '0;
            w.last = 1'b1;
            case (r.req_type)
                REQ_PUSH: begin
                    ring_mem[head_ptr] = r.push_byte;
                    head_ptr = next_slot(head_ptr);
                    if (head_ptr == tail_ptr) begin
                        tail_ptr  = next_slot(tail_ptr);
                        w.dropped = 1'b1;
                    end
                    w.level = LVL_W'(held_count());
                    expected_q.push_back(w);
                end
                REQ_POP: begin
                    if (n == 0) begin
                        w.status = STAT_EMPTY;
                        expected_q.push_back(w);
                    end else begin
                        remove_bytes(1, 1'b0, 0);
                    end
                end
                REQ_DETECT: begin
                    if (n == 0) begin
                        w.status = STAT_EMPTY;
                    end else begin
                        pos      = delim_offset(r.delim_char);
                        w.found  = (pos >= 0);
                        w.status = (pos >= 0) ? STAT_OK : STAT_NOTFOUND;
                        w.level  = LVL_W'(n);
                    end
                    expected_q.push_back(w);
                end
                REQ_TAKE: begin
                    pos = (n == 0) ? -1 : delim_offset(r.delim_char);
                    if (n == 0) begin
                        w.status = STAT_EMPTY;
                        expected_q.push_back(w);
                    end else if (pos < 0) begin
                        w.status = STAT_NOTFOUND;
                        w.level  = LVL_W'(n);
                        expected_q.push_back(w);
                    end else begin
                        remove_bytes(pos + 1, 1'b1, pos + 1);
                    end
                end
                REQ_READ: begin
                    take = (int'(r.read_count) < n) ? int'(r.read_count) : n;
                    if (take == 0) begin
                        w.status = (n == 0) ? STAT_EMPTY : STAT_OK;
                        w.level  = LVL_W'(n);
                        expected_q.push_back(w);
                    end else begin
                        remove_bytes(take, 1'b0, 0);
                    end
                end
                default: begin
                    w.level = LVL_W'(n);
                    expected_q.push_back(w);
                end
            endcase
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_word(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("word with nothing expected: %h", got);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("out_byte", want.out_byte, got.out_byte);
            cmp_field("has_byte", want.has_byte, got.has_byte);
            cmp_field("found", want.found, got.found);
            cmp_field("line_length", want.line_length, got.line_length);
            cmp_field("status", want.status, got.status);
            cmp_field("dropped", want.dropped, got.dropped);
            cmp_field("level", want.level, got.level);
            cmp_field("last", want.last, got.last);
        endfunction
    endclass

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_stall;
    t_req  i_req       = '0;
    logic  o_rsp_valid;
    logic  i_rsp_stall = 1'b0;
    t_rsp  o_rsp;

    ring_scoreboard sb = new();

    int send_idle_pct = 0;   // chance per cycle that the request side idles
    int rsp_idle_pct  = 0;   // chance per cycle that the response side stalls
    int sent          = 0;   // request words accepted so far
    int hold_requests = 0;   // bumped by the stimulus to ask for one long hold-off
    int hold_served   = 0;
    int hold_left     = 0;

    byte_ring_buffer_line_extract_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // response side: sample the word taken at this edge, then pick the next stall;
    // the long hold-off is counted here so the stimulus keeps offering meanwhile
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            sb.check_word(o_rsp);
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
        end
    end

    // offer one request word, optionally after a random idle gap, and wait until taken;
    // valid stays high on return so a back-to-back word never drops it in between
    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_fields(input logic [2:0] req, input logic [7:0] pb,
                               input logic [7:0] dc, input logic [5:0] rc);
        t_req r;
        r.req_type   = req;
        r.push_byte  = pb;
        r.delim_char = dc;
        r.read_count = rc;
        send_req(r);
    endtask

    task automatic push_random();
        send_fields(REQ_PUSH, 8'($urandom), 8'($urandom), 6'($urandom));
    endtask

    // drop valid and hold off until every expected word has come back
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // empty ring answers, ignored codes, field extremes, found and not found cases
    task automatic run_directed();
        send_fields(REQ_POP, 8'h00, 8'h00, 6'd0);
        send_fields(REQ_DETECT, 8'h00, LINE_FEED, 6'd0);
        send_fields(REQ_TAKE, 8'hFF, LINE_FEED, 6'd0);
        send_fields(REQ_READ, 8'h00, 8'hFF, 6'd63);
        send_fields(REQ_SPARE_LO, 8'hFF, 8'hFF, 6'd63);
        send_fields(REQ_SPARE_HI, 8'h00, 8'h00, 6'd0);
        send_fields(REQ_PUSH, 8'h00, 8'hFF, 6'd63);
        send_fields(REQ_PUSH, 8'hFF, 8'h00, 6'd0);
        send_fields(REQ_PUSH, LINE_FEED, 8'h00, 6'd0);
        send_fields(REQ_PUSH, 8'h41, 8'h00, 6'd0);
        // read of zero bytes on a non-empty ring
        send_fields(REQ_READ, 8'h00, 8'h00, 6'd0);
        send_fields(REQ_DETECT, 8'h00, LINE_FEED, 6'd0);
        send_fields(REQ_DETECT, 8'h00, 8'h55, 6'd0);
        send_fields(REQ_TAKE, 8'h00, 8'h55, 6'd0);
        // line of three bytes ending in the line feed
        send_fields(REQ_TAKE, 8'h00, LINE_FEED, 6'd0);
        send_fields(REQ_POP, 8'hFF, 8'hFF, 6'd63);
        send_fields(REQ_POP, 8'h00, 8'h00, 6'd0);
        send_fields(REQ_PUSH, 8'h7E, 8'h00, 6'd0);
        send_fields(REQ_PUSH, 8'h80, 8'h00, 6'd0);
        // count above the level is capped
        send_fields(REQ_READ, 8'h00, 8'h00, 6'd63);
        send_fields(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                    8'($urandom), 8'($urandom), 6'($urandom));
        // zero byte as delimiter at the very tail
        send_fields(REQ_PUSH, 8'h00, 8'h00, 6'd0);
        send_fields(REQ_PUSH, 8'h33, 8'h00, 6'd0);
        send_fields(REQ_TAKE, 8'h00, 8'h00, 6'd0);
    endtask

    // starts with a burst of pushes that may overfill the ring so pushes drop bytes, then mostly
    // push-a-line-and-take-it sequences, with reads, pops and raw noise mixed in
    task automatic run_random(input int quota);
        int         start;
        int         pick;
        logic [7:0] d;
        start = sent;
        repeat ($urandom_range(62, 70)) push_random();
        while (sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : LINE_FEED;
                repeat ($urandom_range(0, 14)) push_random();
                // now and then the line is left unterminated
                if ($urandom_range(0, 9) != 0) begin
                    send_fields(REQ_PUSH, d, 8'($urandom), 6'($urandom));
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_fields(REQ_DETECT, 8'($urandom), d, 6'($urandom));
                end
                send_fields(REQ_TAKE, 8'($urandom), d, 6'($urandom));
            end else if (pick < 65) begin
                send_fields(REQ_READ, 8'($urandom), 8'($urandom),
                            ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 8))
                                                        : 6'($urandom));
            end else if (pick < 72) begin
                send_fields(REQ_POP, 8'($urandom), 8'($urandom), 6'($urandom));
            end else begin
                send_fields(3'($urandom), 8'($urandom), 8'($urandom), 6'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender idles a little, receiver a lot
        send_idle_pct = 28;
        rsp_idle_pct  = 70;
        run_directed();
        run_random(130);

        // sender pauses until the ring has answered everything
        wait_drained();

        // phase 2: the other way round
        send_idle_pct = 70;
        rsp_idle_pct  = 28;
        run_random(140);

        // phase 3: no idling, except one long receiver hold-off that backs up the block
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        hold_requests++;
        run_random(140);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
